// File: rtl/core/ctuds_pkg.sv
// Package for the CTU dependency scoreboard: sizes, function and stage codes,
// sequencer states, inter-module structs and the per-stage neighbor table.
// No dependencies.
package ctuds_pkg;

    // Frame store geometry
    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 256;
    localparam int DEPTH     = MAX_COLS * MAX_ROWS;
    localparam int AW        = $clog2(DEPTH);
    localparam int FS_BITS   = AW + 1;
    localparam int DONE_BITS = 8;

    // Field widths
    localparam int FUNC_BITS    = 3;
    localparam int STAGE_BITS   = 3;
    localparam int COL_BITS     = 8;
    localparam int ROW_BITS     = 8;
    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 2;
    localparam int NB_IDX_BITS  = 3;

    // Effective frame dimension (1..MAX) and signed neighbor coordinate
    localparam int DIM_BITS = (MAX_COLS > MAX_ROWS) ? $clog2(MAX_COLS + 1)
                                                    : $clog2(MAX_ROWS + 1);
    localparam int CRD_BITS = COL_BITS + 2;
    localparam int MUL_W    = (DIM_BITS > CRD_BITS) ? DIM_BITS : CRD_BITS;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int CMP_W    = (CFG_BITS > DIM_BITS) ? CFG_BITS : DIM_BITS;

    // Function codes
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_MARK  = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_QUERY = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_ERROR = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_SCAN  = 3'd4;

    // Stage codes
    localparam logic [STAGE_BITS-1:0] STG_PARSE = 3'd0;
    localparam logic [STAGE_BITS-1:0] STG_INTER = 3'd1;
    localparam logic [STAGE_BITS-1:0] STG_RECON = 3'd2;
    localparam logic [STAGE_BITS-1:0] STG_LMCS  = 3'd3;
    localparam logic [STAGE_BITS-1:0] STG_DBK_V = 3'd4;
    localparam logic [STAGE_BITS-1:0] STG_DBK_H = 3'd5;
    localparam logic [STAGE_BITS-1:0] STG_SAO   = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAVE   = 2'd2;

    // Neighbor offsets
    localparam logic signed [1:0] OFS_M1 = 2'sb11;
    localparam logic signed [1:0] OFS_0  = 2'sb00;
    localparam logic signed [1:0] OFS_P1 = 2'sb01;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MARK_RD,
        S_MARK_WR,
        S_QRY,
        S_SCAN,
        S_RESP
    } state_t;

    // Neighbor coordinate handed to the address unit
    typedef struct packed {
        logic signed [CRD_BITS-1:0] x;
        logic signed [CRD_BITS-1:0] y;
    } crd_t;

    // Effective frame size
    typedef struct packed {
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
    } dims_t;

    // Address unit answer
    typedef struct packed {
        logic          neg;
        logic [AW-1:0] addr;
    } loc_t;

    // Store access request
    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [AW-1:0]        addr;
        logic [DONE_BITS-1:0] wdata;
    } mem_req_t;

    // One neighbor test: offset and the stage bit to check
    typedef struct packed {
        logic signed [1:0]       dx;
        logic signed [1:0]       dy;
        logic [STAGE_BITS-1:0]   stg;
    } nb_t;

    function automatic nb_t mk_nb(input logic signed [1:0] dx,
                                  input logic signed [1:0] dy,
                                  input logic [STAGE_BITS-1:0] stg);
        nb_t r;
        r.dx  = dx;
        r.dy  = dy;
        r.stg = stg;
        return r;
    endfunction

    // Neighbor k of a stage's readiness rule
    function automatic nb_t nb_entry(input logic [STAGE_BITS-1:0] stg,
                                     input logic [1:0] k);
        nb_t r;
        r = mk_nb(OFS_0, OFS_0, STG_PARSE);
        case (stg)
            STG_PARSE: r = mk_nb(OFS_0, OFS_M1, STG_PARSE);
            STG_RECON:
            begin
                case (k)
                    2'd0:    r = mk_nb(OFS_0, OFS_0, STG_INTER);
                    2'd1:    r = mk_nb(OFS_P1, OFS_M1, STG_RECON);
                    default: r = mk_nb(OFS_M1, OFS_0, STG_RECON);
                endcase
            end
            STG_LMCS:
            begin
                case (k)
                    2'd0:    r = mk_nb(OFS_P1, OFS_P1, STG_RECON);
                    2'd1:    r = mk_nb(OFS_0, OFS_P1, STG_RECON);
                    default: r = mk_nb(OFS_P1, OFS_0, STG_RECON);
                endcase
            end
            STG_DBK_V:
            begin
                case (k)
                    2'd0:    r = mk_nb(OFS_0, OFS_0, STG_LMCS);
                    default: r = mk_nb(OFS_P1, OFS_0, STG_LMCS);
                endcase
            end
            STG_DBK_H:
            begin
                case (k)
                    2'd0:    r = mk_nb(OFS_M1, OFS_0, STG_DBK_H);
                    default: r = mk_nb(OFS_0, OFS_0, STG_DBK_V);
                endcase
            end
            STG_SAO:
            begin
                case (k)
                    2'd0:    r = mk_nb(OFS_P1, OFS_M1, STG_SAO);
                    2'd1:    r = mk_nb(OFS_M1, OFS_P1, STG_DBK_H);
                    2'd2:    r = mk_nb(OFS_0, OFS_P1, STG_DBK_H);
                    default: r = mk_nb(OFS_P1, OFS_P1, STG_DBK_H);
                endcase
            end
            default: r = mk_nb(OFS_0, OFS_0, STG_PARSE);
        endcase
        return r;
    endfunction

    // Number of neighbor tests for a stage
    function automatic logic [NB_IDX_BITS-1:0] nb_count(input logic [STAGE_BITS-1:0] stg,
                                                        input logic wave,
                                                        input logic tile_start);
        logic [NB_IDX_BITS-1:0] n;
        case (stg)
            STG_PARSE: n = (wave && !tile_start) ? 3'd1 : 3'd0;
            STG_RECON: n = 3'd3;
            STG_LMCS:  n = 3'd3;
            STG_DBK_V: n = 3'd2;
            STG_DBK_H: n = 3'd2;
            STG_SAO:   n = 3'd4;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // Saturate a size register to 1..lim
    function automatic logic [DIM_BITS-1:0] sat_dim(input logic [CFG_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] lim);
        logic [CMP_W-1:0] ve;
        logic [CMP_W-1:0] le;
        logic [DIM_BITS-1:0] r;
        ve = CMP_W'(v);
        le = CMP_W'(lim);
        if (ve == '0)
            r = DIM_BITS'(1);
        else if (ve > le)
            r = lim;
        else
            r = DIM_BITS'(v);
        return r;
    endfunction

endpackage

// File: rtl/core/ctuds_store.sv
// Done-bit store: one 8-bit entry per coding tree unit, one access per cycle.
// Read data is registered. Depends on ctuds_pkg.
module ctuds_store (
    input  logic                          clk,
    input  ctuds_pkg::mem_req_t           req,
    output logic [ctuds_pkg::DONE_BITS-1:0] rd_data
);
    import ctuds_pkg::*;

    logic [DONE_BITS-1:0] mem [DEPTH];
    logic [DONE_BITS-1:0] rd_data_reg;

    // Single port: write or read at the request address
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ctuds_addr_unit.sv
// Shared address unit: clamps a neighbor coordinate to the frame and forms
// the linear store address row * width + col. Depends on ctuds_pkg.
module ctuds_addr_unit (
    input  ctuds_pkg::crd_t  crd,
    input  ctuds_pkg::dims_t dims,
    output ctuds_pkg::loc_t  loc
);
    import ctuds_pkg::*;

    logic [MUL_W-1:0]  xu;
    logic [MUL_W-1:0]  yu;
    logic [MUL_W-1:0]  wmax;
    logic [MUL_W-1:0]  hmax;
    logic [MUL_W-1:0]  cx;
    logic [MUL_W-1:0]  cy;
    logic [PROD_W-1:0] prod;

    // Negative coordinates count as done; caller skips the read
    assign loc.neg = crd.x[CRD_BITS-1] | crd.y[CRD_BITS-1];

    // Clamp to last column / row
    always_comb
    begin
        xu   = MUL_W'($unsigned(crd.x));
        yu   = MUL_W'($unsigned(crd.y));
        wmax = MUL_W'(dims.w) - MUL_W'(1);
        hmax = MUL_W'(dims.h) - MUL_W'(1);
        cx   = (xu > wmax) ? wmax : xu;
        cy   = (yu > hmax) ? hmax : yu;
        prod = PROD_W'(cy) * PROD_W'(dims.w);
    end

    assign loc.addr = AW'(prod + PROD_W'(cx));

endmodule

// File: rtl/core/ctuds_ctrl.sv
// Sequencer of the CTU dependency scoreboard: config registers, error flag,
// clear/scan sweeps, neighbor test walk and the output register.
// Depends on ctuds_pkg; drives ctuds_addr_unit and ctuds_store.
module ctuds_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // item channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ctuds_pkg::FUNC_BITS-1:0]      func,
    input  logic [ctuds_pkg::STAGE_BITS-1:0]     stage,
    input  logic [ctuds_pkg::COL_BITS-1:0]       col,
    input  logic [ctuds_pkg::ROW_BITS-1:0]       row,
    input  logic                                 tile_row_start,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 ready_res,
    output logic                                 parse_missing,
    output logic                                 error_seen,
    // config channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ctuds_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ctuds_pkg::CFG_BITS-1:0]       cfg_data,
    // address unit
    output ctuds_pkg::crd_t                      crd,
    output ctuds_pkg::dims_t                     dims,
    input  ctuds_pkg::loc_t                      loc,
    // store
    output ctuds_pkg::mem_req_t                  mem_req,
    input  logic [ctuds_pkg::DONE_BITS-1:0]      rd_data
);
    import ctuds_pkg::*;

    state_t state_reg, state_next;

    // config
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    logic                wave_reg;

    // control
    logic                    error_reg, error_next;
    logic                    emit_reg, emit_next;
    logic [FS_BITS-1:0]      cnt_reg, cnt_next;
    logic [FS_BITS-1:0]      frame_size_reg;
    logic [NB_IDX_BITS-1:0]  nb_idx_reg, nb_idx_next;
    logic                    pend_reg, pend_next;
    logic [STAGE_BITS-1:0]   pend_stg_reg, pend_stg_next;
    logic                    ok_reg, ok_next;
    logic                    res_ready_reg, res_ready_next;
    logic                    res_missing_reg, res_missing_next;
    logic                    out_valid_reg, out_valid_next;

    // captured item and output payload
    logic [STAGE_BITS-1:0]   stage_reg, stage_next;
    logic [COL_BITS-1:0]     col_reg, col_next;
    logic [ROW_BITS-1:0]     row_reg, row_next;
    logic                    tile_reg, tile_next;
    logic                    ready_res_reg, ready_res_next;
    logic                    parse_missing_reg, parse_missing_next;
    logic                    error_seen_reg, error_seen_next;

    nb_t                     nb;
    logic [NB_IDX_BITS-1:0]  nb_cnt;
    logic signed [1:0]       ofs_x;
    logic signed [1:0]       ofs_y;
    logic                    ok_chk;
    logic                    in_frame;

    assign cfg_ready = 1'b1;

    // Effective frame size
    assign dims.w = sat_dim(width_reg, DIM_BITS'(MAX_COLS));
    assign dims.h = sat_dim(height_reg, DIM_BITS'(MAX_ROWS));

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_BITS'(1);
            height_reg <= CFG_BITS'(1);
            wave_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_WAVE:   wave_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Neighbor selection and coordinate for the address unit
    assign nb     = nb_entry(stage_reg, nb_idx_reg[1:0]);
    assign nb_cnt = nb_count(stage_reg, wave_reg, tile_reg);
    assign ofs_x  = (state_reg == S_QRY) ? nb.dx : OFS_0;
    assign ofs_y  = (state_reg == S_QRY) ? nb.dy : OFS_0;
    assign crd.x  = $signed({{(CRD_BITS-COL_BITS){1'b0}}, col_reg})
                  + $signed({{(CRD_BITS-2){ofs_x[1]}}, ofs_x});
    assign crd.y  = $signed({{(CRD_BITS-ROW_BITS){1'b0}}, row_reg})
                  + $signed({{(CRD_BITS-2){ofs_y[1]}}, ofs_y});
    assign in_frame = (32'(col_reg) < 32'(dims.w)) && (32'(row_reg) < 32'(dims.h));

    // Next state and outputs
    always_comb
    begin
        state_next         = state_reg;
        error_next         = error_reg;
        emit_next          = emit_reg;
        cnt_next           = cnt_reg;
        nb_idx_next        = nb_idx_reg;
        pend_next          = pend_reg;
        pend_stg_next      = pend_stg_reg;
        ok_next            = ok_reg;
        res_ready_next     = res_ready_reg;
        res_missing_next   = res_missing_reg;
        out_valid_next     = out_valid_reg;
        stage_next         = stage_reg;
        col_next           = col_reg;
        row_next           = row_reg;
        tile_next          = tile_reg;
        ready_res_next     = ready_res_reg;
        parse_missing_next = parse_missing_reg;
        error_seen_next    = error_seen_reg;
        mem_req            = '0;
        ok_chk             = ok_reg;
        in_ready           = (state_reg == S_IDLE);

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = cnt_reg[AW-1:0];
                mem_req.wdata = '0;
                if (cnt_reg[AW-1:0] == AW'(DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = emit_reg ? S_RESP : S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + FS_BITS'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    stage_next       = stage;
                    col_next         = col;
                    row_next         = row;
                    tile_next        = tile_row_start;
                    res_ready_next   = 1'b0;
                    res_missing_next = 1'b0;
                    cnt_next         = '0;
                    nb_idx_next      = '0;
                    pend_next        = 1'b0;
                    ok_next          = 1'b1;
                    case (func)
                        FUNC_CLEAR:
                        begin
                            error_next = 1'b0;
                            emit_next  = 1'b1;
                            state_next = S_CLR;
                        end
                        FUNC_MARK:  state_next = S_MARK_RD;
                        FUNC_QUERY: state_next = S_QRY;
                        FUNC_ERROR:
                        begin
                            error_next = 1'b1;
                            state_next = S_RESP;
                        end
                        FUNC_SCAN:  state_next = S_SCAN;
                        default:    state_next = S_RESP;
                    endcase
                end
            end

            S_MARK_RD:
            begin
                if (in_frame)
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = loc.addr;
                    state_next    = S_MARK_WR;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_MARK_WR:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = loc.addr;
                mem_req.wdata = rd_data | (DONE_BITS'(1) << stage_reg);
                state_next    = S_RESP;
            end

            // one neighbor read issued per cycle, checked the cycle after
            S_QRY:
            begin
                if (pend_reg)
                begin
                    ok_chk = ok_reg & rd_data[pend_stg_reg];
                end
                ok_next = ok_chk;
                if (nb_idx_reg < nb_cnt)
                begin
                    nb_idx_next = nb_idx_reg + NB_IDX_BITS'(1);
                    if (!loc.neg)
                    begin
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = loc.addr;
                        pend_next     = 1'b1;
                        pend_stg_next = nb.stg;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        res_ready_next = error_reg | ok_chk;
                        state_next     = S_RESP;
                    end
                end
            end

            // walk entries 0..W*H-1, stop at the first missing parse bit
            S_SCAN:
            begin
                if (pend_reg && !rd_data[STG_PARSE])
                begin
                    res_missing_next = 1'b1;
                    error_next       = 1'b1;
                    pend_next        = 1'b0;
                    state_next       = S_RESP;
                end
                else if (cnt_reg < frame_size_reg)
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = cnt_reg[AW-1:0];
                    cnt_next      = cnt_reg + FS_BITS'(1);
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    ready_res_next     = res_ready_reg;
                    parse_missing_next = res_missing_reg;
                    error_seen_next    = error_reg;
                    emit_next          = 1'b0;
                    state_next         = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control registers; reset starts a clearing pass over the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            error_reg       <= 1'b0;
            emit_reg        <= 1'b0;
            cnt_reg         <= '0;
            frame_size_reg  <= FS_BITS'(1);
            nb_idx_reg      <= '0;
            pend_reg        <= 1'b0;
            pend_stg_reg    <= '0;
            ok_reg          <= 1'b1;
            res_ready_reg   <= 1'b0;
            res_missing_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            error_reg       <= error_next;
            emit_reg        <= emit_next;
            cnt_reg         <= cnt_next;
            frame_size_reg  <= FS_BITS'(PROD_W'(dims.w) * PROD_W'(dims.h));
            nb_idx_reg      <= nb_idx_next;
            pend_reg        <= pend_next;
            pend_stg_reg    <= pend_stg_next;
            ok_reg          <= ok_next;
            res_ready_reg   <= res_ready_next;
            res_missing_reg <= res_missing_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        stage_reg         <= stage_next;
        col_reg           <= col_next;
        row_reg           <= row_next;
        tile_reg          <= tile_next;
        ready_res_reg     <= ready_res_next;
        parse_missing_reg <= parse_missing_next;
        error_seen_reg    <= error_seen_next;
    end

    assign out_valid     = out_valid_reg;
    assign ready_res     = ready_res_reg;
    assign parse_missing = parse_missing_reg;
    assign error_seen    = error_seen_reg;

`ifndef SYNTHESIS
    // Store is written only by the clearing sweep or a mark update
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg == S_CLR || state_reg == S_MARK_WR))
        else $error("store written outside clear or mark");

    // Clear-frame drops the error flag
    a_clear_err: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == FUNC_CLEAR) |=> !error_reg)
        else $error("error flag survived clear-frame");

    // A scan gap always comes with the error flag
    a_gap_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && parse_missing_reg) |-> error_seen_reg)
        else $error("parse gap reported without error flag");

    // Scan never reads past the frame
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= frame_size_reg))
        else $error("scan counter beyond frame size");

    // Query walk never runs past the stage's neighbor list
    a_nb_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QRY) |-> (nb_idx_reg <= nb_cnt))
        else $error("neighbor index past rule length");
`endif

endmodule

// File: rtl/core/ctu_dependency_scoreboard_top.sv
// Top level of the CTU dependency scoreboard.
// Depends on ctuds_pkg, ctuds_ctrl, ctuds_addr_unit and ctuds_store.
//
// Usage:
//   Item channel (in_valid/in_ready) carries func, stage, col, row and
//   tile_row_start. Each transaction yields exactly one result transaction on
//   out_valid/out_ready: ready_res, parse_missing and error_seen.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   index 0 width, 1 height, 2 wavefront enable. Write it only while idle.
// Operation (an item is finished and its result registered before the next is taken):
//   mark done         read, then write of the unit's entry; no store access outside the frame
//   query             one store read per neighbor test, none for a negative neighbor
//   record error      no store access, as for an unknown func
//   clear frame       all 65536 store entries, one written per cycle
//   scan              up to W*H entries, one read per cycle
//   All of these share the single store port, one access a cycle.
// Reset: a clearing pass over all 65536 entries zeroes the store; in_ready stays low
//   meanwhile, config writes are still taken.
// Stall: a finished result waits in the output register; a second result
//   waits in the sequencer until that register frees, and no item is taken.
module ctu_dependency_scoreboard_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ctuds_pkg::FUNC_BITS-1:0]      func,
    input  logic [ctuds_pkg::STAGE_BITS-1:0]     stage,
    input  logic [ctuds_pkg::COL_BITS-1:0]       col,
    input  logic [ctuds_pkg::ROW_BITS-1:0]       row,
    input  logic                                 tile_row_start,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 ready_res,
    output logic                                 parse_missing,
    output logic                                 error_seen,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ctuds_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ctuds_pkg::CFG_BITS-1:0]       cfg_data
);
    import ctuds_pkg::*;

    crd_t                 crd;
    dims_t                dims;
    loc_t                 loc;
    mem_req_t             mem_req;
    logic [DONE_BITS-1:0] rd_data;

    // Sequencer
    ctuds_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .stage          (stage),
        .col            (col),
        .row            (row),
        .tile_row_start (tile_row_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ready_res      (ready_res),
        .parse_missing  (parse_missing),
        .error_seen     (error_seen),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .crd            (crd),
        .dims           (dims),
        .loc            (loc),
        .mem_req        (mem_req),
        .rd_data        (rd_data)
    );

    // Shared clamp and address unit
    ctuds_addr_unit u_addr (
        .crd  (crd),
        .dims (dims),
        .loc  (loc)
    );

    // Done-bit store
    ctuds_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

// File: sim/tb_ctu_dependency_scoreboard_top.sv
// Testbench for the CTU dependency scoreboard: directed rule checks, frame-size
// extremes, randomized wavefront traffic under three idling regimes and a
// long output stall. Depends on ctuds_pkg and ctu_dependency_scoreboard_top.
`timescale 1ns / 1ps

module tb_ctu_dependency_scoreboard_top;

    import ctuds_pkg::*;

    // Codes the package leaves out
    localparam logic [STAGE_BITS-1:0]   STG_ALF_CODE   = 3'd7;
    localparam logic [FUNC_BITS-1:0]    FUNC_UNUSED_LO = 3'd5;
    localparam logic [FUNC_BITS-1:0]    FUNC_UNUSED_HI = 3'd7;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE      = 2'd3;

    // Cycles without any accepted transaction before the run is called hung
    localparam int STALL_LIMIT = 300000;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic ready_res;
        logic parse_missing;
        logic error_seen;
    } verdict_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [FUNC_BITS-1:0]    func;
    logic [STAGE_BITS-1:0]   stage;
    logic [COL_BITS-1:0]     col;
    logic [ROW_BITS-1:0]     row;
    logic                    tile_row_start;
    logic                    out_valid;
    logic                    out_ready;
    logic                    ready_res;
    logic                    parse_missing;
    logic                    error_seen;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    // Scoreboard mirror: done bits, sticky error and frame registers
    logic [DONE_BITS-1:0] done_mirror [0:DEPTH-1];
    logic                 error_mirror;
    logic [CFG_BITS-1:0]  width_mirror;
    logic [CFG_BITS-1:0]  height_mirror;
    logic                 wave_mirror;

    verdict_t verdict_q[$];

    int err_count;
    int items_sent;
    int idle_cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    int clear_budget;
    logic rx_hold;

    ctu_dependency_scoreboard_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .stage          (stage),
        .col            (col),
        .row            (row),
        .tile_row_start (tile_row_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ready_res      (ready_res),
        .parse_missing  (parse_missing),
        .error_seen     (error_seen),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Mirror of the scoreboard
    // ------------------------------------------------------------------
    function automatic int frame_w();
        int w;
        w = int'(width_mirror);
        if (w < 1)
            w = 1;
        if (w > MAX_COLS)
            w = MAX_COLS;
        return w;
    endfunction

    function automatic int frame_h();
        int h;
        h = int'(height_mirror);
        if (h < 1)
            h = 1;
        if (h > MAX_ROWS)
            h = MAX_ROWS;
        return h;
    endfunction

    // Negative neighbor counts as done, far side clamps to the last unit
    function automatic bit unit_done(input int x, input int y,
                                     input logic [STAGE_BITS-1:0] stg);
        int w;
        int h;
        int cx;
        int cy;
        w = frame_w();
        h = frame_h();
        if (x < 0 || y < 0)
            return 1'b1;
        cx = (x > w - 1) ? w - 1 : x;
        cy = (y > h - 1) ? h - 1 : y;
        return done_mirror[cy * w + cx][stg];
    endfunction

    function automatic bit stage_may_run(input logic [STAGE_BITS-1:0] stg,
                                         input int x, input int y, input bit tile_start);
        case (stg)
            STG_PARSE:
            begin
                if (wave_mirror && !tile_start)
                    return unit_done(x, y - 1, STG_PARSE);
                return 1'b1;
            end
            STG_RECON:
                return unit_done(x, y, STG_INTER) && unit_done(x + 1, y - 1, STG_RECON) &&
                       unit_done(x - 1, y, STG_RECON);
            STG_LMCS:
                return unit_done(x + 1, y + 1, STG_RECON) && unit_done(x, y + 1, STG_RECON) &&
                       unit_done(x + 1, y, STG_RECON);
            STG_DBK_V:
                return unit_done(x, y, STG_LMCS) && unit_done(x + 1, y, STG_LMCS);
            STG_DBK_H:
                return unit_done(x - 1, y, STG_DBK_H) && unit_done(x, y, STG_DBK_V);
            STG_SAO:
                return unit_done(x + 1, y - 1, STG_SAO) && unit_done(x - 1, y + 1, STG_DBK_H) &&
                       unit_done(x, y + 1, STG_DBK_H) && unit_done(x + 1, y + 1, STG_DBK_H);
            default:
                return 1'b1;
        endcase
    endfunction

    // Apply one transaction to the mirror and return the answer it yields
    function automatic verdict_t apply_item(input logic [FUNC_BITS-1:0] f,
                                            input logic [STAGE_BITS-1:0] s,
                                            input logic [COL_BITS-1:0] c,
                                            input logic [ROW_BITS-1:0] r,
                                            input logic t);
        verdict_t v;
        int x;
        int y;
        int w;
        int h;
        v = '0;
        x = int'(c);
        y = int'(r);
        w = frame_w();
        h = frame_h();
        case (f)
            FUNC_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                    done_mirror[i] = '0;
                error_mirror = 1'b0;
            end
            FUNC_MARK:
            begin
                if (x < w && y < h)
                    done_mirror[y * w + x][s] = 1'b1;
            end
            FUNC_QUERY:
                v.ready_res = error_mirror || stage_may_run(s, x, y, t);
            FUNC_ERROR:
                error_mirror = 1'b1;
            FUNC_SCAN:
            begin
                for (int i = 0; i < w * h; i++)
                begin
                    if (!done_mirror[i][STG_PARSE])
                    begin
                        v.parse_missing = 1'b1;
                        error_mirror = 1'b1;
                        break;
                    end
                end
            end
            default: ;
        endcase
        v.error_seen = error_mirror;
        return v;
    endfunction

    task automatic mirror_reset();
        for (int i = 0; i < DEPTH; i++)
            done_mirror[i] = '0;
        error_mirror  = 1'b0;
        width_mirror  = 9'd1;
        height_mirror = 9'd1;
        wave_mirror   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------
    // Register writes update the mirror's frame setup
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_mirror  = cfg_data;
                CFG_HEIGHT: height_mirror = cfg_data;
                CFG_WAVE:   wave_mirror   = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Accepted input transaction: predict its answer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            verdict_q.push_back(apply_item(func, stage, col, row, tile_row_start));
    end

    // Accepted result transaction: compare with the oldest prediction
    always @(posedge clk)
    begin : check_result
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result transaction with nothing pending");
                err_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (ready_res !== want.ready_res)
                begin
                    $error("ready_res expected %0b actual %0b", want.ready_res, ready_res);
                    err_count++;
                end
                if (parse_missing !== want.parse_missing)
                begin
                    $error("parse_missing expected %0b actual %0b",
                           want.parse_missing, parse_missing);
                    err_count++;
                end
                if (error_seen !== want.error_seen)
                begin
                    $error("error_seen expected %0b actual %0b", want.error_seen, error_seen);
                    err_count++;
                end
            end
        end
    end

    // Receiver: random stalls, or a forced hold-off
    always @(posedge clk)
        out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);

    // Watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [FUNC_BITS-1:0] f, input logic [STAGE_BITS-1:0] s,
                             input logic [COL_BITS-1:0] c, input logic [ROW_BITS-1:0] r,
                             input logic t);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= f;
        stage          <= s;
        col            <= c;
        row            <= r;
        tile_row_start <= t;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Waits on the clock first so the prediction of the last accepted item is queued
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high so writes can go back to back
    task automatic cfg_send(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_frame(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                             input logic [CFG_BITS-1:0] wave);
        wait_results_drained();
        cfg_send(CFG_WIDTH, w);
        cfg_send(CFG_HEIGHT, h);
        cfg_send(CFG_WAVE, wave);
        cfg_valid <= 1'b0;
    endtask

    // Mix of query-then-mark on in-frame units, out-of-range noise and rare error, scan, clear and unknown-func items
    task automatic mixed_traffic(input int n_items);
        int target;
        int pick;
        int fw;
        int fh;
        logic [STAGE_BITS-1:0] stg;
        logic [COL_BITS-1:0] cx;
        logic [ROW_BITS-1:0] cy;
        target = items_sent + n_items;
        fw = frame_w();
        fh = frame_h();
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 999);
            stg  = STAGE_BITS'($urandom_range(0, 7));
            cx   = COL_BITS'($urandom_range(0, fw - 1));
            cy   = ROW_BITS'($urandom_range(0, fh - 1));
            if (pick < 700)
            begin
                send_item(FUNC_QUERY, stg, cx, cy, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 4) != 0)
                    send_item(FUNC_MARK, stg, cx, cy, 1'($urandom_range(0, 1)));
            end
            else if (pick < 850)
                send_item(FUNC_QUERY, stg, COL_BITS'($urandom), ROW_BITS'($urandom),
                          1'($urandom_range(0, 1)));
            else if (pick < 950)
                send_item(FUNC_MARK, stg, COL_BITS'($urandom), ROW_BITS'($urandom),
                          1'($urandom_range(0, 1)));
            else if (pick < 980)
                send_item(FUNC_BITS'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)), stg,
                          COL_BITS'($urandom), ROW_BITS'($urandom), 1'($urandom_range(0, 1)));
            else if (pick < 983)
                send_item(FUNC_ERROR, stg, cx, cy, 1'($urandom_range(0, 1)));
            else if (pick < 986)
                send_item(FUNC_SCAN, stg, cx, cy, 1'($urandom_range(0, 1)));
            else if (pick < 988 && clear_budget > 0)
            begin
                clear_budget--;
                send_item(FUNC_CLEAR, stg, COL_BITS'($urandom), ROW_BITS'($urandom),
                          1'($urandom_range(0, 1)));
            end
            else
                send_item(FUNC_QUERY, stg, cx, cy, 1'($urandom_range(0, 1)));
        end
    endtask

    // Scan, mark parse on every unit, scan again, then poison the flag and ask once more
    task automatic parse_sweep_and_scan();
        int fw;
        int fh;
        fw = frame_w();
        fh = frame_h();
        send_item(FUNC_SCAN, STG_PARSE, 8'd0, 8'd0, 1'b0);
        for (int y = 0; y < fh; y++)
            for (int x = 0; x < fw; x++)
                send_item(FUNC_MARK, STG_PARSE, COL_BITS'(x), ROW_BITS'(y),
                          1'($urandom_range(0, 1)));
        send_item(FUNC_SCAN, STAGE_BITS'($urandom_range(0, 7)), 8'd0, 8'd0, 1'b1);
        send_item(FUNC_ERROR, STG_PARSE, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_SAO, COL_BITS'($urandom_range(0, fw - 1)),
                  ROW_BITS'($urandom_range(0, fh - 1)), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Registers written during the post-reset clearing pass
    task automatic test_reset_config();
        cfg_send(CFG_SPARE, 9'h1AA);
        set_frame(9'd4, 9'd3, 9'd1);
    endtask

    task automatic test_directed_rules();
        // wavefront parse: above row, tile start, above out of frame
        send_item(FUNC_QUERY, STG_PARSE, 8'd1, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_PARSE, 8'd1, 8'd1, 1'b0);
        send_item(FUNC_QUERY, STG_PARSE, 8'd1, 8'd1, 1'b1);
        send_item(FUNC_MARK, STG_PARSE, 8'd1, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_PARSE, 8'd1, 8'd1, 1'b0);
        // recon needs inter at the unit
        send_item(FUNC_QUERY, STG_RECON, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_MARK, STG_INTER, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_RECON, 8'd0, 8'd0, 1'b0);
        // lmcs at the corner clamps all neighbors onto the corner
        send_item(FUNC_QUERY, STG_LMCS, 8'd3, 8'd2, 1'b0);
        send_item(FUNC_MARK, STG_RECON, 8'd3, 8'd2, 1'b0);
        send_item(FUNC_QUERY, STG_LMCS, 8'd3, 8'd2, 1'b0);
        send_item(FUNC_QUERY, STG_LMCS, 8'd255, 8'd255, 1'b1);
        // marks outside the frame are dropped
        send_item(FUNC_MARK, STG_ALF_CODE, 8'd255, 8'd255, 1'b1);
        send_item(FUNC_MARK, STG_LMCS, 8'd4, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_DBK_V, 8'd3, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_DBK_H, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_SAO, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_INTER, 8'd2, 8'd1, 1'b0);
        send_item(FUNC_QUERY, STG_ALF_CODE, 8'd2, 8'd1, 1'b0);
        send_item(FUNC_UNUSED_LO, STG_RECON, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_UNUSED_HI, STG_ALF_CODE, 8'd255, 8'd255, 1'b1);
        // scan with gaps raises the flag so the query passes; clear-frame drops it again
        send_item(FUNC_SCAN, STG_PARSE, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_RECON, 8'd2, 8'd2, 1'b0);
        send_item(FUNC_ERROR, STG_PARSE, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_CLEAR, STG_PARSE, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_RECON, 8'd2, 8'd2, 1'b0);
        // full parse coverage: scan finds no gap
        set_frame(9'd2, 9'd1, 9'd0);
        send_item(FUNC_MARK, STG_PARSE, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_MARK, STG_PARSE, 8'd1, 8'd0, 1'b0);
        send_item(FUNC_SCAN, STG_PARSE, 8'd0, 8'd0, 1'b0);
    endtask

    // Saturating size registers and the largest frame
    task automatic test_frame_extremes();
        set_frame(9'd0, 9'd511, 9'h1FF);
        send_item(FUNC_MARK, STG_PARSE, 8'd0, 8'd254, 1'b0);
        send_item(FUNC_QUERY, STG_PARSE, 8'd0, 8'd255, 1'b0);
        send_item(FUNC_QUERY, STG_PARSE, 8'd255, 8'd255, 1'b0);
        send_item(FUNC_MARK, STG_ALF_CODE, 8'd1, 8'd0, 1'b1);
        send_item(FUNC_QUERY, STG_LMCS, 8'd0, 8'd255, 1'b0);
        set_frame(9'd511, 9'd0, 9'd1);
        send_item(FUNC_MARK, STG_RECON, 8'd255, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_LMCS, 8'd255, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_LMCS, 8'd254, 8'd200, 1'b0);
        send_item(FUNC_MARK, STG_SAO, 8'd0, 8'd1, 1'b0);
        set_frame(9'd257, 9'd256, 9'h100);
        send_item(FUNC_MARK, STG_DBK_H, 8'd255, 8'd255, 1'b1);
        send_item(FUNC_QUERY, STG_SAO, 8'd255, 8'd254, 1'b0);
        send_item(FUNC_QUERY, STG_SAO, 8'd254, 8'd254, 1'b0);
        send_item(FUNC_MARK, STG_PARSE, 8'd0, 8'd0, 1'b0);
        send_item(FUNC_QUERY, STG_PARSE, 8'd0, 8'd1, 1'b0);
        set_frame(9'd256, 9'd256, 9'd1);
        mixed_traffic(24);
        send_item(FUNC_SCAN, STG_PARSE, 8'd255, 8'd255, 1'b1);
        send_item(FUNC_CLEAR, STG_ALF_CODE, 8'd255, 8'd255, 1'b1);
        send_item(FUNC_QUERY, STG_SAO, 8'd255, 8'd0, 1'b1);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
        int fw;
        int fh;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int p = 0; p < 2; p++)
        begin
            fw = $urandom_range(1, 8);
            fh = $urandom_range(1, 8);
            set_frame(CFG_BITS'(fw), CFG_BITS'(fh), CFG_BITS'($urandom_range(0, 511)));
            if (p == 0)
                send_item(FUNC_CLEAR, STAGE_BITS'($urandom_range(0, 7)), COL_BITS'($urandom),
                          ROW_BITS'($urandom), 1'($urandom_range(0, 1)));
            mixed_traffic(n_items / 2 - fw * fh - 5);
            parse_sweep_and_scan();
        end
    endtask

    // Receiver holds off while items keep coming, so the input side stalls
    task automatic test_backpressure();
        set_frame(9'd5, 9'd4, 9'd1);
        send_item(FUNC_CLEAR, STG_PARSE, 8'd0, 8'd0, 1'b0);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        mixed_traffic(40);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = FUNC_CLEAR;
        stage          = STG_PARSE;
        col            = '0;
        row            = '0;
        tile_row_start = 1'b0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_WIDTH;
        cfg_data       = '0;
        rx_hold        = 1'b0;
        err_count      = 0;
        items_sent     = 0;
        idle_cycles    = 0;
        clear_budget   = 2;
        tx_idle_pct    = 19;
        rx_idle_pct    = 73;
        mirror_reset();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_config();
        test_directed_rules();
        test_frame_extremes();
        test_random_traffic(19, 73, 590);
        test_random_traffic(73, 19, 590);
        test_random_traffic(0, 0, 590);
        test_backpressure();

        wait_results_drained();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
